FILE: hw/rtl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants and types of the vector normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package vn_pkg;

    localparam int NUM_LANES  = 4;
    localparam int OUT_WIDTH  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 3;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_FOUR_COMPONENTS = 1'b0;

    // Per-word side information that travels beside the lane pipelines.
    typedef struct packed {
        logic [NUM_LANES-1:0] neg;
        logic [NUM_LANES-1:0] act;
        logic                 zero;
    } t_side;

endpackage

`default_nettype wire

FILE: hw/rtl/vn_if.sv
// ----------------------------------------------------------------------------
// vn_in_if / vn_out_if
// Valid/ready channels that carry the input vector and the unit vector.
// ----------------------------------------------------------------------------
`default_nettype none

interface vn_in_if #(parameter int IN_WIDTH = 16);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] comp_x;
    logic signed [IN_WIDTH-1:0] comp_y;
    logic signed [IN_WIDTH-1:0] comp_z;
    logic signed [IN_WIDTH-1:0] comp_w;

    modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
    modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface vn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] unit_x;
    logic signed [15:0] unit_y;
    logic signed [15:0] unit_z;
    logic signed [15:0] unit_w;
    logic               zero_length;

    modport source (output valid, unit_x, unit_y, unit_z, unit_w, zero_length,
                    input ready);
    modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, zero_length,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/vector_normalize.sv
// ----------------------------------------------------------------------------
// vector_normalize
// Scales a four-component Q8.8 vector to unit length in Q1.14.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake      Carries
//  i_vec    in         valid/ready    comp_x, comp_y, comp_z, comp_w
//  o_unit   out        valid/ready    unit_x..unit_w, zero_length
//  APB      in         psel/penable   four_components at byte address 0
//
// A word is taken every cycle unless o_unit stalls, and passes through the
// square, sum and search setup stages, the per-lane search, which resolves
// one quotient bit per stage over OUT_FRAC_BITS + 1 stages, and the output
// stage. The whole pipeline advances together; it only holds while a
// finished word waits at o_unit. Reset clears the valid line and sets
// four_components; data registers are not reset.
//
`default_nettype none

module vector_normalize #(
    parameter int IN_WIDTH      = 16,
    parameter int OUT_FRAC_BITS = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    vn_in_if.sink                              i_vec,
    vn_out_if.source                           o_unit,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [vn_pkg::ADDR_WIDTH-1:0] i_paddr,
    input  wire logic [vn_pkg::DATA_WIDTH-1:0] i_pwdata,
    output logic      [vn_pkg::DATA_WIDTH-1:0] o_prdata,
    output logic                               o_pready
);
    import vn_pkg::*;

    localparam int W     = IN_WIDTH;
    localparam int F     = OUT_FRAC_BITS;
    localparam int NSIDE = F + 2;          // search depth in stages
    localparam int DEPTH = F + 5;          // total pipeline depth in stages
    localparam int MW    = F + 17;         // signing width, at least OUT_WIDTH

    // Configuration register. The user must write it only while the pipe is idle; the block does not enforce this.
    logic r_four;
    logic reg_hit;

    assign reg_hit  = (i_paddr[ADDR_WIDTH-1] == REG_FOUR_COMPONENTS);
    assign o_pready = 1'b1;
    assign o_prdata = reg_hit ? DATA_WIDTH'(r_four) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four <= 1'b1;
        end else if (i_psel && i_penable && i_pwrite && reg_hit) begin
            r_four <= i_pwdata[0];
        end
    end

    // One enable moves every stage; it drops only when the output word
    // is held by the sink.
    logic r_vld [DEPTH];
    logic en;

    assign en          = !r_vld[DEPTH-1] || o_unit.ready;
    assign i_vec.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_vec.valid;
            for (int s = 1; s < DEPTH; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Lane squares; inactive lanes enter as zero.
    logic [NUM_LANES-1:0][W-1:0]   comp;
    logic [NUM_LANES-1:0]          act_in;
    logic [NUM_LANES-1:0][2*W-2:0] sq1;
    logic [NUM_LANES-1:0]          neg1;
    logic [NUM_LANES-1:0]          act1;

    assign comp   = {i_vec.comp_w, i_vec.comp_z, i_vec.comp_y, i_vec.comp_x};
    assign act_in = {r_four, r_four, 2'b11};

    vn_sq #(.W(W)) u_sq (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_comp (comp),
        .i_act  (act_in),
        .o_sq   (sq1),
        .o_neg  (neg1),
        .o_act  (act1)
    );

    // Merge: sum of squares and the zero-length flag.
    logic [NUM_LANES-1:0][2*W-2:0] sq2;
    logic [2*W:0]                  s2;
    t_side                         side2;

    vn_sum #(.W(W)) u_sum (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (sq1),
        .i_neg  (neg1),
        .i_act  (act1),
        .o_sq   (sq2),
        .o_s    (s2),
        .o_side (side2)
    );

    // Four quotient searches side by side.
    logic [NUM_LANES-1:0][F:0] q;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        vn_search #(.W(W), .F(F)) u_search (
            .i_clk (i_clk),
            .i_en  (en),
            .i_sq  (sq2[l]),
            .i_s   (s2),
            .o_q   (q[l])
        );
    end

    // Side information follows the searches stage by stage.
    t_side r_sd [NSIDE];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= side2;
            for (int s = 1; s < NSIDE; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
        end
    end

    // Output stage: clamp to 1.0, apply the sign, force zero where needed.
    logic [NUM_LANES-1:0][OUT_WIDTH-1:0] unit;
    logic [F:0]                          qc;
    logic [MW-1:0]                       mq;
    logic [MW-1:0]                       sv;

    always_comb begin
        unit = '0;
        qc   = '0;
        mq   = '0;
        sv   = '0;
        for (int l = 0; l < NUM_LANES; l++) begin
            qc = (q[l] > ((F+1)'(1) << F)) ? ((F+1)'(1) << F) : q[l];
            mq = MW'(qc);
            sv = r_sd[NSIDE-1].neg[l] ? (~mq + MW'(1)) : mq;
            if (r_sd[NSIDE-1].zero || !r_sd[NSIDE-1].act[l]) begin
                unit[l] = '0;
            end else begin
                unit[l] = sv[OUT_WIDTH-1:0];
            end
        end
    end

    logic [NUM_LANES-1:0][OUT_WIDTH-1:0] r_unit;
    logic                                r_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_unit <= unit;
            r_zero <= r_sd[NSIDE-1].zero;
        end
    end

    assign o_unit.valid       = r_vld[DEPTH-1];
    assign o_unit.unit_x      = r_unit[0];
    assign o_unit.unit_y      = r_unit[1];
    assign o_unit.unit_z      = r_unit[2];
    assign o_unit.unit_w      = r_unit[3];
    assign o_unit.zero_length = r_zero;

`ifndef ASSERT_OFF
    a_zero_gives_zeros: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_unit.valid && o_unit.zero_length) |->
        (r_unit == '0))
        else $error("zero-length word with nonzero components");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && $past(i_rst_n)) |=> (r_vld[0] == $past(r_vld[0])))
        else $error("pipeline moved during an output stall");

    a_reset_mode: assert property (@(posedge i_clk)
        !i_rst_n |=> r_four)
        else $error("four_components not set after reset");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_unit.valid && !o_unit.ready) |-> !i_vec.ready)
        else $error("input taken while output word held");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/vn_sq.sv
// ----------------------------------------------------------------------------
// vn_sq
// Per-lane magnitude and square of the incoming components.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_sq #(
    parameter int W = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic [vn_pkg::NUM_LANES-1:0][W-1:0]  i_comp,
    input  wire logic [vn_pkg::NUM_LANES-1:0]         i_act,
    output logic      [vn_pkg::NUM_LANES-1:0][2*W-2:0] o_sq,
    output logic      [vn_pkg::NUM_LANES-1:0]         o_neg,
    output logic      [vn_pkg::NUM_LANES-1:0]         o_act
);
    import vn_pkg::*;

    logic [NUM_LANES-1:0][W-1:0]   mag;
    logic [NUM_LANES-1:0][2*W-1:0] prod;
    logic [NUM_LANES-1:0][2*W-2:0] r_sq;
    logic [NUM_LANES-1:0]          r_neg;
    logic [NUM_LANES-1:0]          r_act;

    // The most negative code maps to 2^(W-1), which W unsigned bits hold.
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (!i_act[l]) begin
                mag[l] = '0;
            end else if (i_comp[l][W-1]) begin
                mag[l] = ~i_comp[l] + W'(1);
            end else begin
                mag[l] = i_comp[l];
            end
            prod[l] = mag[l] * mag[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_sq[l] <= prod[l][2*W-2:0];
            end
            r_neg <= i_comp_sign(i_comp);
            r_act <= i_act;
        end
    end

    function automatic logic [NUM_LANES-1:0] i_comp_sign(
        input logic [NUM_LANES-1:0][W-1:0] c
    );
        logic [NUM_LANES-1:0] s;
        for (int l = 0; l < NUM_LANES; l++) begin
            s[l] = c[l][W-1];
        end
        return s;
    endfunction

    assign o_sq  = r_sq;
    assign o_neg = r_neg;
    assign o_act = r_act;

endmodule

`default_nettype wire

FILE: hw/rtl/vn_sum.sv
// ----------------------------------------------------------------------------
// vn_sum
// Merges the lane squares into the sum of squares and the zero flag.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_sum #(
    parameter int W = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic [vn_pkg::NUM_LANES-1:0][2*W-2:0] i_sq,
    input  wire logic [vn_pkg::NUM_LANES-1:0]          i_neg,
    input  wire logic [vn_pkg::NUM_LANES-1:0]          i_act,
    output logic      [vn_pkg::NUM_LANES-1:0][2*W-2:0] o_sq,
    output logic      [2*W:0]                          o_s,
    output vn_pkg::t_side                              o_side
);
    import vn_pkg::*;

    logic [2*W:0]                  sum;
    logic [NUM_LANES-1:0][2*W-2:0] r_sq;
    logic [2*W:0]                  r_s;
    t_side                         r_side;

    always_comb begin
        sum = (((2*W+1)'(i_sq[0]) + (2*W+1)'(i_sq[1]))
             + ((2*W+1)'(i_sq[2]) + (2*W+1)'(i_sq[3])));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq        <= i_sq;
            r_s         <= sum;
            r_side.neg  <= i_neg;
            r_side.act  <= i_act;
            r_side.zero <= (sum == '0);
        end
    end

    assign o_sq   = r_sq;
    assign o_s    = r_s;
    assign o_side = r_side;

endmodule

`default_nettype wire

FILE: hw/rtl/vn_search.sv
// ----------------------------------------------------------------------------
// vn_search
// One lane: finds q = round(|c| * 2^F / sqrt(S)) one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_search #(
    parameter int W = 16,
    parameter int F = 14
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [2*W-2:0] i_sq,
    input  wire logic [2*W:0]   i_s,
    output logic      [F:0]     o_q
);
    localparam int EW = 2*W + 2*F + 7;
    localparam int SW = 2*W + 1;
    localparam int NS = F + 2;

    // The residual is 4c^2 2^(2F) - (2q-1)^2 S, the slope is (2q-1) S.
    // Setting bit k of q subtracts 2^(k+2) slope + 2^(2k+2) S from the residual.
    logic [EW-1:0] r_e  [NS];
    logic [EW-1:0] r_a  [NS];
    logic [SW-1:0] r_sv [NS];
    logic [F:0]    r_q  [NS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e[0]  <= (EW'(i_sq) << (2*F + 2)) - EW'(i_s);
            r_a[0]  <= '0 - EW'(i_s);
            r_sv[0] <= i_s;
            r_q[0]  <= '0;
        end
    end

    for (genvar j = 0; j <= F; j++) begin : g_bit
        localparam int K = F - j;
        logic [EW-1:0] trial;
        logic          accept;

        always_comb begin
            trial  = r_e[j] - (r_a[j] << (K + 2)) - (EW'(r_sv[j]) << (2*K + 2));
            accept = !trial[EW-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_e[j+1]  <= accept ? trial : r_e[j];
                r_a[j+1]  <= accept ? r_a[j] + (EW'(r_sv[j]) << (K + 1)) : r_a[j];
                r_sv[j+1] <= r_sv[j];
                r_q[j+1]  <= r_q[j] | ((F+1)'(accept) << K);
            end
        end
    end

    assign o_q = r_q[NS-1];

endmodule

`default_nettype wire

FILE: tb/sv/tb_vn_checker.sv
// ----------------------------------------------------------------------------
// tb_vn_checker
// Watches the vector and unit channels and the register port of the
// normalizer, predicts each unit vector and compares it with the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_vn_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    vn_in_if                                   vec,
    vn_out_if                                  unit,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic                          i_pready,
    input  wire logic [vn_pkg::ADDR_WIDTH-1:0] i_paddr,
    input  wire logic [vn_pkg::DATA_WIDTH-1:0] i_pwdata,
    output int                                 o_fail_count,
    output int                                 o_outstanding
);

    localparam int FRAC = 14;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] w;
        logic        zl;
    } t_unit_vec;

    t_unit_vec unit_queue[$];
    logic      four_comp;

    // Rounded quotient |c| * 2^FRAC / sqrt(s), ties away from zero, found by
    // a search on (2q - 1)^2 * s <= c^2 * 2^(2*FRAC+2).
    function automatic logic [15:0] scaled_comp(logic signed [15:0] c,
                                                longint unsigned s);
        longint unsigned mag;
        longint unsigned c2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        mag = (c < 0) ? longint'(-int'(c)) : longint'(c);
        c2  = mag * mag;
        lo  = 0;
        hi  = 64'd1 << FRAC;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            t   = 2 * mid - 1;
            if (t * t * s <= (c2 << (2 * FRAC + 2))) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return (c < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic t_unit_vec normalized(logic signed [15:0] x, logic signed [15:0] y,
                                             logic signed [15:0] z, logic signed [15:0] w,
                                             logic four);
        t_unit_vec       r;
        longint unsigned s;
        s = longint'(int'(x) * int'(x)) + longint'(int'(y) * int'(y));
        if (four) begin
            s += longint'(int'(z) * int'(z)) + longint'(int'(w) * int'(w));
        end
        r = '0;
        if (s == 0) begin
            r.zl = 1'b1;
        end else begin
            r.x = scaled_comp(x, s);
            r.y = scaled_comp(y, s);
            if (four) begin
                r.z = scaled_comp(z, s);
                r.w = scaled_comp(w, s);
            end
        end
        return r;
    endfunction

    task automatic cmp_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        four_comp     = 1'b1;
    end

    // Sampling at the falling edge sees the values the next rising edge acts on.
    always @(negedge i_clk) begin
        t_unit_vec exp_u;
        if (!i_rst_n) begin
            four_comp = 1'b1;
            unit_queue.delete();
        end else begin
            if (unit.valid && unit.ready) begin
                if (unit_queue.size() == 0) begin
                    $display("%0t: unexpected unit word, expected none, actual %h %h %h %h %b",
                             $time, unit.unit_x, unit.unit_y, unit.unit_z, unit.unit_w,
                             unit.zero_length);
                    o_fail_count++;
                end else begin
                    exp_u = unit_queue.pop_front();
                    cmp_field("unit_x", exp_u.x, unit.unit_x);
                    cmp_field("unit_y", exp_u.y, unit.unit_y);
                    cmp_field("unit_z", exp_u.z, unit.unit_z);
                    cmp_field("unit_w", exp_u.w, unit.unit_w);
                    cmp_field("zero_length", 16'(exp_u.zl), 16'(unit.zero_length));
                end
            end
            if (vec.valid && vec.ready) begin
                unit_queue.push_back(normalized(vec.comp_x, vec.comp_y, vec.comp_z,
                                                vec.comp_w, four_comp));
            end
            // Only the register at word index zero exists; bit 0 is kept.
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[vn_pkg::ADDR_WIDTH-1:2] == 0) begin
                four_comp = i_pwdata[0];
            end
        end
        o_outstanding = unit_queue.size();
    end

    final begin
        if (unit_queue.size() != 0) begin
            $display("%0t: %0d unit words never arrived", $time, unit_queue.size());
        end
    end

endmodule

FILE: tb/sv/tb_vector_normalize.sv
// ----------------------------------------------------------------------------
// tb_vector_normalize
// Drives vectors and register writes into the normalizer under varying
// backpressure, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_vector_normalize;

    // Extra wait after the last expected unit word has arrived.
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;
    localparam int RAND_ITEMS   = 645;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_psel;
    logic                          i_penable;
    logic                          i_pwrite;
    logic [vn_pkg::ADDR_WIDTH-1:0] i_paddr;
    logic [vn_pkg::DATA_WIDTH-1:0] i_pwdata;
    logic [vn_pkg::DATA_WIDTH-1:0] o_prdata;
    logic                          o_pready;

    int fail_count;
    int outstanding;
    int idle_in;
    int idle_out;
    int stall_cnt;

    vn_in_if #(.IN_WIDTH(16)) vec_ch ();
    vn_out_if                 unit_ch ();

    vector_normalize dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vec     (vec_ch),
        .o_unit    (unit_ch),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    tb_vn_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .vec           (vec_ch),
        .unit          (unit_ch),
        .i_psel        (i_psel),
        .i_penable     (i_penable),
        .i_pwrite      (i_pwrite),
        .i_pready      (o_pready),
        .i_paddr       (i_paddr),
        .i_pwdata      (i_pwdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // The receiver stalls at random with the probability of the phase.
    always @(posedge i_clk) begin
        unit_ch.ready <= ($urandom_range(0, 99) >= idle_out);
    end

    // Watchdog: counts cycles in which no word and no register write moves.
    always @(negedge i_clk) begin
        if ((vec_ch.valid && vec_ch.ready) || (unit_ch.valid && unit_ch.ready) ||
            (i_psel && i_penable) || !i_rst_n) begin
            stall_cnt = 0;
        end else begin
            stall_cnt++;
        end
        if (stall_cnt >= STALL_LIMIT) begin
            $display("vector_normalize regression: fail");
            $finish;
        end
    end

    // Offers one word and returns at the rising edge at which it is taken.
    // The ready line is looked at on the falling edge, where it is stable.
    task automatic send_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [15:0] w);
        logic taken;
        while ($urandom_range(0, 99) < idle_in) begin
            vec_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        vec_ch.valid  <= 1'b1;
        vec_ch.comp_x <= x;
        vec_ch.comp_y <= y;
        vec_ch.comp_z <= z;
        vec_ch.comp_w <= w;
        do begin
            @(negedge i_clk);
            taken = vec_ch.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain();
        vec_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // A register write is only issued while the pipeline is empty.
    task automatic reg_write(logic [vn_pkg::ADDR_WIDTH-1:0] addr,
                             logic [vn_pkg::DATA_WIDTH-1:0] data);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= addr;
        i_pwdata  <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] extreme_comp();
        unique case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0001;
            3:       return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    // Mostly full-range and short vectors, with zeros and extremes mixed in.
    task automatic send_random();
        logic [15:0] c[4];
        int          pick;
        pick = $urandom_range(0, 99);
        for (int i = 0; i < 4; i++) begin
            if (pick < 40) begin
                c[i] = 16'($urandom);
            end else if (pick < 70) begin
                c[i] = 16'($signed($urandom_range(0, 511)) - 256);
            end else if (pick < 85) begin
                c[i] = ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'($urandom);
            end else if (pick < 90) begin
                // Zero in the leading pair; z and w still random for two-lane mode.
                c[i] = (i < 2) ? 16'h0000 : 16'($urandom);
            end else begin
                c[i] = extreme_comp();
            end
        end
        if (pick >= 85 && pick < 87) begin
            c = '{16'h0, 16'h0, 16'h0, 16'h0};
        end
        send_vec(c[0], c[1], c[2], c[3]);
    endtask

    task automatic random_phase(int in_idle, int out_idle);
        idle_in  = in_idle;
        idle_out = out_idle;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            // Halfway through, the sender holds off until the pipeline is empty.
            if (n == RAND_ITEMS / 2) begin
                drain();
            end
            send_random();
        end
        drain();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_psel           = 1'b0;
        i_penable        = 1'b0;
        i_pwrite         = 1'b0;
        i_paddr          = '0;
        i_pwdata         = '0;
        vec_ch.valid     = 1'b0;
        vec_ch.comp_x    = '0;
        vec_ch.comp_y    = '0;
        vec_ch.comp_z    = '0;
        vec_ch.comp_w    = '0;
        unit_ch.ready    = 1'b0;
        idle_in          = 16;
        idle_out         = 51;
        stall_cnt        = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Four-lane mode straight from reset: zero vector, axes, extremes.
        send_vec(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_vec(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        send_vec(16'h8000, 16'h0000, 16'h0000, 16'h0000);
        send_vec(16'h0000, 16'h0001, 16'h0000, 16'h0000);
        send_vec(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        send_vec(16'h0000, 16'h0000, 16'h0000, 16'h8000);
        send_vec(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_vec(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_vec(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF);
        send_vec(16'h0100, 16'h0100, 16'h0100, 16'h0100);
        send_vec(16'h0003, 16'h0004, 16'h0000, 16'h0000);
        send_vec(16'h0001, 16'h0001, 16'h0001, 16'hFFFF);
        drain();

        // A write to a register index that does not exist leaves four lanes on.
        reg_write(3'd4, 32'h0000_0000);
        send_vec(16'h0001, 16'h0002, 16'h0002, 16'h0000);
        drain();

        // Two-lane mode: z and w are ignored, even when x and y are zero.
        reg_write(3'd0, 32'h0000_0000);
        send_vec(16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
        send_vec(16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF);
        send_vec(16'h8000, 16'h0000, 16'h0000, 16'h0000);
        send_vec(16'h0003, 16'hFFFC, 16'h7FFF, 16'h7FFF);
        send_vec(16'hFFFF, 16'h0001, 16'h8000, 16'h8000);
        send_vec(16'h0000, 16'h7FFF, 16'h0000, 16'h0001);
        drain();

        // Only bit 0 of the written value counts.
        reg_write(3'd0, 32'hFFFF_FFFF);
        random_phase(16, 51);
        reg_write(3'd0, 32'hFFFF_FFFE);
        random_phase(51, 16);
        reg_write(3'd4, 32'hFFFF_FFFF);
        reg_write(3'd0, 32'h0000_0001);
        random_phase(0, 0);

        if (fail_count == 0) begin
            $display("vector_normalize regression: pass");
        end else begin
            $display("vector_normalize regression: fail");
        end
        $finish;
    end

endmodule
